[rtl/ipts_pkg.sv]
package ipts_pkg;

  localparam int MAX_LEN_DEF  = 4096;
  localparam int QUAD_SLOTS   = 4;
  localparam int GROUP_DIGITS = 3;
  localparam int LAST_GROUP   = 3;
  localparam int OUT_POS_W    = 13;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;
  localparam int R_DEPTH      = 2;
  localparam logic [7:0] DOT_BYTE = 8'h2E;

  // classified input word
  typedef struct packed {
    logic is_digit;
    logic is_alnum;
    logic is_dot;
    logic last;
  } cls_t;

  typedef struct packed {
    logic                 ip_found;
    logic [OUT_POS_W-1:0] ip_start;
    logic [OUT_POS_W-1:0] ip_end;
    logic                 port_found;
    logic [OUT_POS_W-1:0] port_start;
    logic [OUT_POS_W-1:0] port_end;
    logic                 too_long;
  } res_t;

  function automatic cls_t classify(input logic [7:0] c, input logic last);
    cls_t w;
    w.is_digit = (c >= 8'h30) && (c <= 8'h39);
    w.is_alnum = w.is_digit || ((c >= 8'h41) && (c <= 8'h5A)) ||
                 ((c >= 8'h61) && (c <= 8'h7A));
    w.is_dot   = (c == DOT_BYTE);
    w.last     = last;
    return w;
  endfunction

endpackage

[rtl/ipts_front.sv]
module ipts_front import ipts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       in_push,
  output logic       in_full,
  output logic       q_valid,
  output cls_t       q_word,
  input  logic       q_pop
);

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            push, pop;

  assign in_full = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_word  = mem_r[rd_ptr_r];
  assign push    = in_push && !in_full;
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= classify(in_ch, in_last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[rtl/ipts_back.sv]
module ipts_back import ipts_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cls_t q_word,
  output logic q_pop,
  output res_t res,
  output logic res_empty,
  input  logic res_pop
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             prev_alnum_r, prev_alnum_nxt;
  logic             t_act_r [QUAD_SLOTS], t_act_nxt [QUAD_SLOTS];
  logic [POS_W-1:0] t_start_r [QUAD_SLOTS], t_start_nxt [QUAD_SLOTS];
  logic [1:0]       t_grp_r [QUAD_SLOTS], t_grp_nxt [QUAD_SLOTS];
  logic [1:0]       t_dig_r [QUAD_SLOTS], t_dig_nxt [QUAD_SLOTS];
  logic             p_act_r, p_act_nxt;
  logic [POS_W-1:0] p_start_r, p_start_nxt;
  logic [POS_W-1:0] skip_r, skip_nxt;
  logic             taken_r, taken_nxt;
  logic [POS_W-1:0] qs_r, qs_nxt, qe_r, qe_nxt;
  logic             pseen_r, pseen_nxt;
  logic [POS_W-1:0] ps_r, ps_nxt, pe_r, pe_nxt;
  logic             ovf_r, ovf_nxt;
  res_t             new_res;
  logic             step;

  res_t             rq_r [R_DEPTH];
  logic             rwr_r, rrd_r;
  logic [1:0]       rcnt_r;
  logic             rfull, rpush, rpop;

  assign rfull = (rcnt_r == 2'(R_DEPTH));
  assign step  = q_valid && !rfull;
  assign q_pop = step;

  always_comb begin
    logic           succ;
    logic [2:0]     n;
    logic           keep;
    logic           win;
    logic           done;
    logic [1:0]     dg;
    logic [1:0]     gp;
    pos_nxt        = pos_r;
    prev_alnum_nxt = prev_alnum_r;
    t_act_nxt      = t_act_r;
    t_start_nxt    = t_start_r;
    t_grp_nxt      = t_grp_r;
    t_dig_nxt      = t_dig_r;
    p_act_nxt      = p_act_r;
    p_start_nxt    = p_start_r;
    skip_nxt       = skip_r;
    taken_nxt      = taken_r;
    qs_nxt         = qs_r;
    qe_nxt         = qe_r;
    pseen_nxt      = pseen_r;
    ps_nxt         = ps_r;
    pe_nxt         = pe_r;
    ovf_nxt        = ovf_r;
    new_res        = '0;
    rpush          = 1'b0;
    succ           = 1'b0;
    n              = '0;
    keep           = 1'b0;
    win            = 1'b0;
    done           = 1'b0;
    dg             = '0;
    gp             = '0;
    if (step) begin
      if (pos_r < MAX_POS) begin
        // advance quad candidates, oldest first, packing survivors
        for (int i = 0; i < QUAD_SLOTS; i++) t_act_nxt[i] = 1'b0;
        for (int i = 0; i < QUAD_SLOTS; i++) begin
          keep = 1'b0;
          win  = 1'b0;
          dg   = t_dig_r[i];
          gp   = t_grp_r[i];
          if (t_dig_r[i] == 2'd0) begin
            keep = q_word.is_digit;
            dg   = 2'd1;
          end else if (q_word.is_digit) begin
            keep = (t_dig_r[i] < 2'(GROUP_DIGITS));
            dg   = t_dig_r[i] + 2'd1;
          end else if (t_grp_r[i] == 2'(LAST_GROUP)) begin
            win = 1'b1;
          end else if (q_word.is_dot) begin
            keep = 1'b1;
            gp   = t_grp_r[i] + 2'd1;
            dg   = 2'd0;
          end
          if (t_act_r[i] && !succ) begin
            if (win) begin
              succ      = 1'b1;
              taken_nxt = 1'b1;
              qs_nxt    = t_start_r[i];
              qe_nxt    = pos_r;
              skip_nxt  = pos_r;
            end else if (keep) begin
              t_act_nxt[n[1:0]]   = 1'b1;
              t_start_nxt[n[1:0]] = t_start_r[i];
              t_grp_nxt[n[1:0]]   = gp;
              t_dig_nxt[n[1:0]]   = dg;
              n = n + 3'd1;
            end
          end
        end
        if (succ) begin
          for (int i = 0; i < QUAD_SLOTS; i++) t_act_nxt[i] = 1'b0;
          p_act_nxt = 1'b0;
        end
        // port run
        if (p_act_nxt && !q_word.is_digit) begin
          p_act_nxt = 1'b0;
          if (!q_word.is_dot) begin
            pseen_nxt = 1'b1;
            ps_nxt    = p_start_r;
            pe_nxt    = pos_r;
          end
        end
        // new candidate start
        if (q_word.is_digit && (pos_r == '0 || !prev_alnum_r) && pos_r >= skip_nxt) begin
          if (!taken_nxt) begin
            for (int i = 0; i < QUAD_SLOTS; i++) begin
              if (!t_act_nxt[i] && !done) begin
                done           = 1'b1;
                t_act_nxt[i]   = 1'b1;
                t_start_nxt[i] = pos_r;
                t_grp_nxt[i]   = 2'd0;
                t_dig_nxt[i]   = 2'd1;
              end
            end
          end
          p_act_nxt   = 1'b1;
          p_start_nxt = pos_r;
        end
        prev_alnum_nxt = q_word.is_alnum;
        pos_nxt        = pos_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end

      if (q_word.last) begin
        succ = 1'b0;
        for (int i = 0; i < QUAD_SLOTS; i++) begin
          if (t_act_nxt[i] && !succ && t_grp_nxt[i] == 2'(LAST_GROUP) &&
              t_dig_nxt[i] != 2'd0) begin
            succ      = 1'b1;
            taken_nxt = 1'b1;
            qs_nxt    = t_start_nxt[i];
            qe_nxt    = pos_nxt;
          end
        end
        if (p_act_nxt && !succ) begin
          pseen_nxt = 1'b1;
          ps_nxt    = p_start_nxt;
          pe_nxt    = pos_nxt;
        end
        rpush              = 1'b1;
        new_res.ip_found   = taken_nxt;
        new_res.ip_start   = taken_nxt ? OUT_POS_W'(qs_nxt) : '0;
        new_res.ip_end     = taken_nxt ? OUT_POS_W'(qe_nxt) : '0;
        new_res.port_found = pseen_nxt;
        new_res.port_start = pseen_nxt ? OUT_POS_W'(ps_nxt) : '0;
        new_res.port_end   = pseen_nxt ? OUT_POS_W'(pe_nxt) : '0;
        new_res.too_long   = ovf_nxt;
        // back to the idle state for the next string
        pos_nxt        = '0;
        prev_alnum_nxt = 1'b0;
        for (int i = 0; i < QUAD_SLOTS; i++) t_act_nxt[i] = 1'b0;
        p_act_nxt = 1'b0;
        skip_nxt  = '0;
        taken_nxt = 1'b0;
        qs_nxt    = '0;
        qe_nxt    = '0;
        pseen_nxt = 1'b0;
        ps_nxt    = '0;
        pe_nxt    = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_start_r <= t_start_nxt;
    t_grp_r   <= t_grp_nxt;
    t_dig_r   <= t_dig_nxt;
    p_start_r <= p_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      prev_alnum_r <= 1'b0;
      for (int i = 0; i < QUAD_SLOTS; i++) t_act_r[i] <= 1'b0;
      p_act_r      <= 1'b0;
      skip_r       <= '0;
      taken_r      <= 1'b0;
      qs_r         <= '0;
      qe_r         <= '0;
      pseen_r      <= 1'b0;
      ps_r         <= '0;
      pe_r         <= '0;
      ovf_r        <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      prev_alnum_r <= prev_alnum_nxt;
      t_act_r      <= t_act_nxt;
      p_act_r      <= p_act_nxt;
      skip_r       <= skip_nxt;
      taken_r      <= taken_nxt;
      qs_r         <= qs_nxt;
      qe_r         <= qe_nxt;
      pseen_r      <= pseen_nxt;
      ps_r         <= ps_nxt;
      pe_r         <= pe_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // result queue
  assign rpop      = res_pop && !res_empty;
  assign res_empty = (rcnt_r == 2'd0);
  assign res       = rq_r[rrd_r];

  always_ff @(posedge clk) begin
    if (rpush) begin
      rq_r[rwr_r] <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rwr_r  <= 1'b0;
      rrd_r  <= 1'b0;
      rcnt_r <= 2'd0;
    end else begin
      if (rpush) rwr_r <= ~rwr_r;
      if (rpop)  rrd_r <= ~rrd_r;
      if (rpush && !rpop) rcnt_r <= rcnt_r + 2'd1;
      else if (rpop && !rpush) rcnt_r <= rcnt_r - 2'd1;
    end
  end

endmodule

[rtl/ip_port_text_splitter_core.sv]
// flow: a word is scanned once it leaves the input queue; the result of a string
// enters the result queue when its last byte is scanned
// throughput: one byte per cycle while the result queue is not full, set by the candidate tracker update
// reset: synchronous active-low rst_n empties both queues and clears the scanner
module ip_port_text_splitter_core import ipts_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  input  logic                 push,
  output logic                 full,
  output logic                 out_ip_found,
  output logic [OUT_POS_W-1:0] out_ip_start,
  output logic [OUT_POS_W-1:0] out_ip_end,
  output logic                 out_port_found,
  output logic [OUT_POS_W-1:0] out_port_start,
  output logic [OUT_POS_W-1:0] out_port_end,
  output logic                 out_too_long,
  output logic                 empty,
  input  logic                 pop
);

  logic q_valid, q_pop;
  cls_t q_word;
  res_t res;

  ipts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .in_last (in_last),
    .in_push (push),
    .in_full (full),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  ipts_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_ip_found   = res.ip_found;
  assign out_ip_start   = res.ip_start;
  assign out_ip_end     = res.ip_end;
  assign out_port_found = res.port_found;
  assign out_port_start = res.port_start;
  assign out_port_end   = res.port_end;
  assign out_too_long   = res.too_long;

endmodule
